/* rtl/chacha20_keystream_xor_top_macros.svh */
// assertion macros used by the checker file
`ifndef CHACHA20_KEYSTREAM_XOR_TOP_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_TOP_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define CKX_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define CKX_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/ckx_pkg.sv */
// shared types, constants and functions of the chacha20 keystream xor block
package ckx_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNTER = 3'd6;

  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       wrap_error;
  } out_item_t;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [3:0][31:0]  quad_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
    logic [63:0]      start_counter;
  } cfg_t;

  // finished block handed from the generator to the byte path
  typedef struct packed {
    logic valid;
    logic wrap;
    blk_t words;
  } pend_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // one half of a quarter round: rotations 16/12 on the first half, 8/7 on the second
  function automatic quad_t qr_half(input quad_t w, input logic second);
    logic [31:0] a, b, c, d;
    quad_t       r;
    a = w[0];
    b = w[1];
    c = w[2];
    d = w[3];
    a = a + b;
    d = second ? rotl(d ^ a, 8) : rotl(d ^ a, 16);
    c = c + d;
    b = second ? rotl(b ^ c, 7) : rotl(b ^ c, 12);
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

  function automatic blk_t build_matrix(input cfg_t c, input logic [31:0] ctr,
                                        input logic [31:0] nctr);
    blk_t m;
    m[0]  = SIGMA_0;
    m[1]  = SIGMA_1;
    m[2]  = SIGMA_2;
    m[3]  = SIGMA_3;
    m[4]  = c.key[0][31:0];
    m[5]  = c.key[0][63:32];
    m[6]  = c.key[1][31:0];
    m[7]  = c.key[1][63:32];
    m[8]  = c.key[2][31:0];
    m[9]  = c.key[2][63:32];
    m[10] = c.key[3][31:0];
    m[11] = c.key[3][63:32];
    m[12] = ctr;
    m[13] = nctr;
    m[14] = c.nonce_low[63:32];
    m[15] = c.nonce_high;
    return m;
  endfunction

endpackage

/* rtl/ckx_fifo.sv */
// small register queue, used for the input side and the result side
module ckx_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/ckx_block_gen.sv */
// keystream block generator: half quarter rounds on all four lanes per cycle
module ckx_block_gen import ckx_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  restart_i,
  input  logic  take_i,
  output pend_t pend_o
);

  localparam int unsigned NSTEP = 4 * DOUBLE_ROUNDS;
  localparam int unsigned SW    = $clog2(NSTEP);

  localparam logic [1:0] GS_IDLE = 2'd0;
  localparam logic [1:0] GS_RUN  = 2'd1;
  localparam logic [1:0] GS_FIN  = 2'd2;
  localparam logic [1:0] GS_FULL = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic [31:0]   ctr_q, ctr_d, nctr_q, nctr_d;
  logic          wrap_q, wrap_d, pwrap_q, pwrap_d;
  blk_t          x_q, x_d, in_m, rnd;
  logic          carry_wrap;

  assign in_m       = build_matrix(cfg_i, ctr_q, nctr_q);
  assign carry_wrap = (&ctr_q) && (&nctr_q);

  // step bit 0 picks the half of the quarter round, bit 1 column or diagonal
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    quad_t      qi, qo;
    rnd = x_q;
    for (int i = 0; i < 4; i++) begin
      ia = 4'(i);
      ib = step_q[1] ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
      ic = step_q[1] ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
      id = step_q[1] ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
      qi[0] = x_q[ia];
      qi[1] = x_q[ib];
      qi[2] = x_q[ic];
      qi[3] = x_q[id];
      qo = qr_half(qi, step_q[0]);
      rnd[ia] = qo[0];
      rnd[ib] = qo[1];
      rnd[ic] = qo[2];
      rnd[id] = qo[3];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ctr_d   = ctr_q;
    nctr_d  = nctr_q;
    wrap_d  = wrap_q;
    pwrap_d = pwrap_q;
    x_d     = x_q;
    if (restart_i) begin
      state_d = GS_IDLE;
      ctr_d   = cfg_i.start_counter[31:0];
      nctr_d  = cfg_i.nonce_low[31:0] + cfg_i.start_counter[63:32];
      wrap_d  = 1'b0;
    end else begin
      unique case (state_q)
        GS_IDLE: begin
          x_d     = in_m;
          step_d  = '0;
          state_d = GS_RUN;
        end
        GS_RUN: begin
          x_d    = rnd;
          step_d = step_q + 1'b1;
          if (step_q == SW'(NSTEP - 1)) begin
            state_d = GS_FIN;
          end
        end
        GS_FIN: begin
          for (int i = 0; i < 16; i++) begin
            x_d[i] = x_q[i] + in_m[i];
          end
          ctr_d   = ctr_q + 1'b1;
          nctr_d  = (&ctr_q) ? nctr_q + 1'b1 : nctr_q;
          wrap_d  = wrap_q | carry_wrap;
          pwrap_d = wrap_q | carry_wrap;
          state_d = GS_FULL;
        end
        GS_FULL: begin
          if (take_i) begin
            state_d = GS_IDLE;
          end
        end
        default: state_d = GS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GS_IDLE;
      step_q  <= '0;
      ctr_q   <= '0;
      nctr_q  <= '0;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ctr_q   <= ctr_d;
      nctr_q  <= nctr_d;
      wrap_q  <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    pwrap_q <= pwrap_d;
  end

  assign pend_o.valid = (state_q == GS_FULL);
  assign pend_o.wrap  = pwrap_q;
  assign pend_o.words = x_q;

endmodule

/* rtl/ckx_byte_path.sv */
// back end: holds the current keystream block and xors one byte per cycle when input, result room and a block are there
module ckx_byte_path import ckx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      restart_i,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output out_item_t out_item_o,
  input  pend_t     pend_i,
  output logic      take_o
);

  blk_t        cur_q;
  logic        cur_wrap_q, cur_valid_q, cur_valid_d;
  logic [5:0]  pos_q, pos_d;
  logic        fire, blk_end;
  logic [31:0] word;

  assign fire    = in_valid_i && cur_valid_q && !out_full_i && !restart_i;
  assign blk_end = fire && (&pos_q);
  assign take_o  = pend_i.valid && !restart_i && (!cur_valid_q || blk_end);

  assign word                  = cur_q[pos_q[5:2]];
  assign out_item_o.out_byte   = in_item_i.data_byte ^ word[{pos_q[1:0], 3'b000} +: 8];
  assign out_item_o.last_out   = in_item_i.last;
  assign out_item_o.wrap_error = cur_wrap_q;
  assign out_push_o            = fire;
  assign in_pop_o              = fire;

  always_comb begin
    cur_valid_d = cur_valid_q;
    pos_d       = pos_q;
    if (restart_i) begin
      cur_valid_d = 1'b0;
      pos_d       = '0;
    end else begin
      if (fire) begin
        pos_d = pos_q + 1'b1;
      end
      if (take_o) begin
        cur_valid_d = 1'b1;
      end else if (blk_end) begin
        cur_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      cur_q      <= pend_i.words;
      cur_wrap_q <= pend_i.wrap;
    end
  end

endmodule

/* rtl/chacha20_keystream_xor_top.sv */
// chacha20 keystream xor: top level with configuration registers and queues
//
// Input bytes are pushed with push while full is low; results are read with
// pop while empty is low, oldest first, one result per input byte.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
// registers 0..6 hold key, nonce and start counter, and any write to one of
// them restarts the stream. Indexes beyond the list are ignored.
// A byte passes from the head of the input queue through the xor into the
// registered result queue once a keystream block is on hand. The first block
// after reset or a restart is built in steps: one load, two half-round steps
// per round, one feed-forward add, one hand-over. Throughput: one byte per cycle
// while bytes wait and the result queue has room; the generator refills its
// spare block while the 64 bytes of the current one are used.
// Reset clears all configuration to zero, empties both queues and drops any
// keystream. When pop stays low, results collect in the result queue, then
// the input queue fills and full rises; no byte is lost or reordered.
module chacha20_keystream_xor_top import ckx_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t      cfg_q, cfg_d;
  logic      cfg_hit, restart_q, restart;
  logic      in_empty, in_pop, out_full, out_push, take;
  in_item_t  in_head;
  out_item_t out_new;
  pend_t     pend;

  always_comb begin
    cfg_d   = cfg_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      cfg_hit = 1'b1;
      unique case (cfg_idx_i)
        CFG_KEY_WORD_0:    cfg_d.key[0]        = cfg_wdata_i;
        CFG_KEY_WORD_1:    cfg_d.key[1]        = cfg_wdata_i;
        CFG_KEY_WORD_2:    cfg_d.key[2]        = cfg_wdata_i;
        CFG_KEY_WORD_3:    cfg_d.key[3]        = cfg_wdata_i;
        CFG_NONCE_LOW:     cfg_d.nonce_low     = cfg_wdata_i;
        CFG_NONCE_HIGH:    cfg_d.nonce_high    = cfg_wdata_i[31:0];
        CFG_START_COUNTER: cfg_d.start_counter = cfg_wdata_i;
        default:           cfg_hit             = 1'b0;
      endcase
    end
  end

  // the registered restart reloads the counters from the freshly written values
  assign restart = cfg_hit || restart_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      restart_q <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      restart_q <= cfg_hit;
    end
  end

  ckx_fifo #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .wdata_i (in_item_i),
    .pop_i   (in_pop),
    .empty_o (in_empty),
    .rdata_o (in_head)
  );

  ckx_block_gen #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (restart),
    .take_i    (take),
    .pend_o    (pend)
  );

  ckx_byte_path u_path (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .in_valid_i (!in_empty),
    .in_item_i  (in_head),
    .in_pop_o   (in_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_item_o (out_new),
    .pend_i     (pend),
    .take_o     (take)
  );

  ckx_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .full_o  (out_full),
    .wdata_i (out_new),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_item_o)
  );

endmodule

/* rtl/ckx_checker.sv */
// port-level checker for the chacha20 keystream xor block, bound to the top
`include "chacha20_keystream_xor_top_macros.svh"

module ckx_checker import ckx_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // checked in the cycle after reset is sampled, once the reset has reached the queue counters
  `CKX_ASSERT_RST(a_reset_clears, !rst_ni |=> (empty && !full), "queues not cleared by reset")
  `CKX_ASSERT_CLK(a_result_holds, (!empty && !pop) |=> !empty, "waiting result vanished")
  `CKX_ASSERT_CLK(a_payload_holds, (!empty && !pop) |=> $stable(out_item_o), "waiting result changed")

endmodule

bind chacha20_keystream_xor_top ckx_checker u_ckx_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

/* test/chacha20_keystream_xor_top_tb.sv */
// testbench for the chacha20 keystream xor block: random byte stream checked against a predictor
`timescale 1ns / 100ps

module chacha20_keystream_xor_top_tb;
  import ckx_pkg::*;

  localparam int unsigned NUM_DROUNDS  = DOUBLE_ROUNDS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned GEN_LATENCY  = 4 * NUM_DROUNDS + 3;
  localparam int unsigned HOLDOFF_LEN  = 400;
  localparam int unsigned HOLDOFF_AT   = 320;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_item_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  chacha20_keystream_xor_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [63:0] key_r [4];
  logic [63:0] nonce_lo_r, start_ctr_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] blk_ctr, nonce_ctr;
  logic [31:0] ks_w [16];
  int unsigned ks_pos;
  logic        wrapped;

  in_item_t  byte_q [$];
  out_item_t cipher_q [$];

  int unsigned fail_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned holdoff_left = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void qround(input int a, input int b, input int c, input int d);
    ks_w[a] = ks_w[a] + ks_w[b]; ks_w[d] = rol32(ks_w[d] ^ ks_w[a], 16);
    ks_w[c] = ks_w[c] + ks_w[d]; ks_w[b] = rol32(ks_w[b] ^ ks_w[c], 12);
    ks_w[a] = ks_w[a] + ks_w[b]; ks_w[d] = rol32(ks_w[d] ^ ks_w[a], 8);
    ks_w[c] = ks_w[c] + ks_w[d]; ks_w[b] = rol32(ks_w[b] ^ ks_w[c], 7);
  endfunction

  function automatic void restart_stream();
    blk_ctr   = start_ctr_r[31:0];
    nonce_ctr = nonce_lo_r[31:0] + start_ctr_r[63:32];
    ks_pos    = 64;
    wrapped   = 1'b0;
  endfunction

  function automatic void next_block();
    logic [31:0] init_m [16];
    init_m[0] = SIGMA_0;
    init_m[1] = SIGMA_1;
    init_m[2] = SIGMA_2;
    init_m[3] = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      init_m[4 + 2 * k] = key_r[k][31:0];
      init_m[5 + 2 * k] = key_r[k][63:32];
    end
    init_m[12] = blk_ctr;
    init_m[13] = nonce_ctr;
    init_m[14] = nonce_lo_r[63:32];
    init_m[15] = nonce_hi_r;
    ks_w = init_m;
    for (int r = 0; r < NUM_DROUNDS; r++) begin
      qround(0, 4, 8, 12);
      qround(1, 5, 9, 13);
      qround(2, 6, 10, 14);
      qround(3, 7, 11, 15);
      qround(0, 5, 10, 15);
      qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);
      qround(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_w[i] = ks_w[i] + init_m[i];
    blk_ctr = blk_ctr + 1;
    if (blk_ctr == 0) begin
      nonce_ctr = nonce_ctr + 1;
      if (nonce_ctr == 0) wrapped = 1'b1;
    end
  endfunction

  function automatic out_item_t encrypt_byte(input in_item_t it);
    out_item_t   res;
    logic [31:0] w;
    if (ks_pos >= 64) begin
      next_block();
      ks_pos = 0;
    end
    w = ks_w[ks_pos / 4];
    res.out_byte   = it.data_byte ^ w[(ks_pos % 4) * 8 +: 8];
    res.last_out   = it.last;
    res.wrap_error = wrapped;
    ks_pos++;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch at result %0d: %s got %0h expected %0h", result_cnt, what, got, want);
    fail_cnt++;
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_KEY_WORD_0:    key_r[0] = val;
      CFG_KEY_WORD_1:    key_r[1] = val;
      CFG_KEY_WORD_2:    key_r[2] = val;
      CFG_KEY_WORD_3:    key_r[3] = val;
      CFG_NONCE_LOW:     nonce_lo_r = val;
      CFG_NONCE_HIGH:    nonce_hi_r = val[31:0];
      CFG_START_COUNTER: start_ctr_r = val;
      default:           ;
    endcase
    if (idx <= CFG_START_COUNTER) restart_stream();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_bytes(input int unsigned n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data_byte = 8'($urandom);
      it.last      = ($urandom_range(0, 7) == 0);
      byte_q.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || cipher_q.size() != 0) @(posedge clk_i);
    repeat (GEN_LATENCY + 5) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        cipher_q.push_back(encrypt_byte(in_item_i));
        void'(byte_q.pop_front());
        send_gap = pick_gap();
      end
      if (push && full) begin
        // transaction still offered, hold it
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (byte_q.size() != 0) begin
        push      <= 1'b1;
        in_item_i <= byte_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (cipher_q.size() == 0) begin
          $display("unexpected result %0h", out_item_o);
          fail_cnt++;
        end else begin
          want = cipher_q.pop_front();
          if (out_item_o.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_item_o.out_byte, want.out_byte);
          if (out_item_o.last_out !== want.last_out)
            report_mismatch("last_out", 8'(out_item_o.last_out), 8'(want.last_out));
          if (out_item_o.wrap_error !== want.wrap_error)
            report_mismatch("wrap_error", 8'(out_item_o.wrap_error), 8'(want.wrap_error));
        end
        result_cnt++;
        if (result_cnt == HOLDOFF_AT) holdoff_left = HOLDOFF_LEN;
        else recv_gap = pick_gap();
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("chacha20_keystream_xor_top test failed");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    for (int k = 0; k < 4; k++) key_r[k] = '0;
    nonce_lo_r  = '0;
    nonce_hi_r  = '0;
    start_ctr_r = '0;
    for (int i = 0; i < 16; i++) ks_w[i] = '0;
    restart_stream();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all-zero key and nonce, field extremes
    no_idle = 1'b1;
    for (int i = 0; i < 12; i++) begin
      it.data_byte = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hff : 8'ha5;
      it.last      = i[0];
      byte_q.push_back(it);
    end
    wait_drained();

    // all ones everywhere, counter wraps word 13 on the first block
    no_idle = 1'b0;
    write_reg(CFG_KEY_WORD_0, '1);
    write_reg(CFG_KEY_WORD_1, '1);
    write_reg(CFG_KEY_WORD_2, '1);
    write_reg(CFG_KEY_WORD_3, '1);
    write_reg(CFG_NONCE_HIGH, '1);
    write_reg(CFG_NONCE_LOW, 64'hffff_ffff_0000_0000);
    write_reg(CFG_START_COUNTER, '1);
    queue_bytes(70);
    wait_drained();

    // wrap on the second block, with an ignored write in the middle of the stream
    write_reg(CFG_START_COUNTER, 64'h0000_0001_ffff_fffe);
    write_reg(CFG_NONCE_LOW, 64'h1234_5678_ffff_fffe);
    queue_bytes(30);
    wait_drained();
    write_reg(CFG_IDX_UNUSED, '1);
    queue_bytes(110);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 3);
      for (int r = 0; r <= CFG_START_COUNTER; r++)
        if ($urandom_range(0, 2) == 0 || r == ph % 7)
          write_reg(r[CFG_IDX_W-1:0], pick_value());
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_START_COUNTER, {$urandom, 32'hffff_ffff - $urandom_range(0, 2)});
      if (ph == 5) write_reg(CFG_IDX_UNUSED, pick_value());
      queue_bytes(ph == 1 ? 250 : 20 + $urandom_range(0, 40));
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("chacha20_keystream_xor_top test passed");
    end else begin
      $display("chacha20_keystream_xor_top test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ckx_pkg.sv
rtl/ckx_fifo.sv
rtl/ckx_block_gen.sv
rtl/ckx_byte_path.sv
rtl/chacha20_keystream_xor_top.sv
rtl/ckx_checker.sv
test/chacha20_keystream_xor_top_tb.sv
